>>> hdl/gcpb_pkg.sv
package gcpb_pkg;

  localparam int MaxCells = 4096;
  localparam int CellAw   = $clog2(MaxCells);
  localparam int CoordW   = 32;
  localparam int SizeW    = 31;
  localparam int DimW     = 13;
  localparam int CountW   = 32;
  localparam int IdW      = 13;
  localparam int DivSteps = CoordW;
  localparam int StepW    = $clog2(DivSteps);
  localparam int WalkW    = CellAw + 1;
  localparam int CfgAw    = 3;

  localparam logic [DimW-1:0]   DimMax    = DimW'(4096);
  localparam logic [WalkW-1:0]  CellLimit = WalkW'(MaxCells);
  localparam logic [IdW-1:0]    NO_BLOCK  = {IdW{1'b1}};
  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  localparam logic [CfgAw-1:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [CfgAw-1:0] CFG_TOP_Y     = 3'd1;
  localparam logic [CfgAw-1:0] CFG_CELL_SIZE = 3'd2;
  localparam logic [CfgAw-1:0] CFG_GRID_COLS = 3'd3;
  localparam logic [CfgAw-1:0] CFG_GRID_ROWS = 3'd4;

  typedef enum logic [1:0] {
    REQ_BIN    = 2'd0,
    REQ_NUMBER = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] top_y;
    logic [SizeW-1:0]         cell_size;
    logic [DimW-1:0]          grid_cols;
    logic [DimW-1:0]          grid_rows;
  } cfg_t;

  // Classified request as it waits in the queue
  typedef struct packed {
    req_t              kind;
    logic              neg;
    logic [CoordW-1:0] off_x;
    logic [CoordW-1:0] off_y;
    logic [CellAw-1:0] sel;
  } item_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > DimMax) r = DimMax;
    return r;
  endfunction

endpackage

>>> hdl/gcpb_ram.sv
module gcpb_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096,
  localparam int Aw = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [Aw-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [Aw-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/gcpb_front.sv
module gcpb_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gcpb_pkg::cfg_t                 cfg,
  input  logic                           hold,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic signed [gcpb_pkg::CoordW-1:0] in_point_x,
  input  logic signed [gcpb_pkg::CoordW-1:0] in_point_y,
  input  logic [gcpb_pkg::CellAw-1:0]    in_cell_select,
  input  logic                           pop,
  output logic                           q_valid,
  output gcpb_pkg::item_t                q_item
);

  localparam int Ow = gcpb_pkg::CoordW + 1;

  logic signed [Ow-1:0] off_x, off_y;
  gcpb_pkg::item_t      item;
  gcpb_pkg::item_t      q_mem_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 push;

  // Offsets from the left and top edges; a negative one is off the grid
  assign off_x = Ow'(in_point_x) - Ow'(cfg.origin_x);
  assign off_y = Ow'(cfg.top_y) - Ow'(in_point_y);

  always_comb begin
    item.kind  = gcpb_pkg::req_t'(in_req_type);
    item.neg   = off_x[Ow-1] | off_y[Ow-1];
    item.off_x = off_x[gcpb_pkg::CoordW-1:0];
    item.off_y = off_y[gcpb_pkg::CoordW-1:0];
    item.sel   = in_cell_select;
  end

  assign in_stall = hold || (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= item;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> hdl/gcpb_back.sv
module gcpb_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gcpb_pkg::cfg_t                    cfg,
  input  logic                              q_valid,
  input  gcpb_pkg::item_t                   q_item,
  output logic                              pop,
  output logic                              clearing,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gcpb_pkg::CellAw-1:0]       out_cell_index,
  output logic                              out_outside,
  output logic [gcpb_pkg::CountW-1:0]       out_cell_count,
  output logic signed [gcpb_pkg::IdW-1:0]   out_block_id,
  output logic [gcpb_pkg::IdW-1:0]          out_total_blocks
);

  localparam int Aw  = gcpb_pkg::CellAw;
  localparam int Cw  = gcpb_pkg::CoordW;
  localparam int Sw  = gcpb_pkg::SizeW;
  localparam int Dw  = gcpb_pkg::DimW;
  localparam int Nw  = gcpb_pkg::CountW;
  localparam int Iw  = gcpb_pkg::IdW;
  localparam int Ww  = gcpb_pkg::WalkW;
  localparam int Xw  = Aw + Dw;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_CHECK, S_MUL, S_BRD, S_BWR,
    S_NUM, S_RRD, S_RDONE, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  gcpb_pkg::item_t item_r, item_nxt;
  logic [gcpb_pkg::StepW-1:0] step_r, step_nxt;
  logic [Ww-1:0] walk_r, walk_nxt;
  logic [Sw-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [Cw-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [Aw-1:0] col_r, col_nxt, row_r, row_nxt;
  logic          miss_r, miss_nxt;
  logic [Xw-1:0] idx_r, idx_nxt;
  logic [Iw-1:0] ncells_r, ncells_nxt, next_r, next_nxt, total_r, total_nxt;
  logic          pv_r, pv_nxt;
  logic [Aw-1:0] pidx_r, pidx_nxt;
  logic [Aw-1:0] res_index_r, res_index_nxt;
  logic          res_out_r, res_out_nxt;
  logic [Nw-1:0] res_count_r, res_count_nxt;
  logic [Iw-1:0] res_bid_r, res_bid_nxt, res_total_r, res_total_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [Aw-1:0] o_index_r, o_index_nxt;
  logic          o_out_r, o_out_nxt;
  logic [Nw-1:0] o_count_r, o_count_nxt;
  logic [Iw-1:0] o_bid_r, o_bid_nxt, o_total_r, o_total_nxt;

  logic [Sw-1:0] csz;
  logic [Dw-1:0] cols, rows;
  logic [2*Dw-1:0] area;
  logic [Cw+Sw-1:0] stx, sty;
  logic          miss_x, miss_y;
  logic [Nw-1:0] bumped;

  logic          cnt_we, bid_we;
  logic [Aw-1:0] cnt_waddr, cnt_raddr, bid_waddr, bid_raddr;
  logic [Nw-1:0] cnt_wdata, cnt_rdata;
  logic [Iw-1:0] bid_wdata, bid_rdata;

  // One restoring division step: returns {remainder, quotient/dividend}
  function automatic logic [Cw+Sw-1:0] div_step(input logic [Sw-1:0] rem,
                                                input logic [Cw-1:0] q,
                                                input logic [Sw-1:0] d);
    logic [Sw:0] trial;
    logic [Sw:0] diff;
    trial = {rem, q[Cw-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) return {diff[Sw-1:0], q[Cw-2:0], 1'b1};
    return {trial[Sw-1:0], q[Cw-2:0], 1'b0};
  endfunction

  gcpb_ram #(.Width(Nw), .Depth(gcpb_pkg::MaxCells)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  gcpb_ram #(.Width(Iw), .Depth(gcpb_pkg::MaxCells)) u_ids (
    .clk(clk), .we(bid_we), .waddr(bid_waddr), .wdata(bid_wdata),
    .raddr(bid_raddr), .rdata(bid_rdata)
  );

  assign csz  = (cfg.cell_size == '0) ? Sw'(1) : cfg.cell_size;
  assign cols = gcpb_pkg::clamp_dim(cfg.grid_cols);
  assign rows = gcpb_pkg::clamp_dim(cfg.grid_rows);
  assign area = cols * rows;
  assign stx  = div_step(rx_r, qx_r, csz);
  assign sty  = div_step(ry_r, qy_r, csz);

  // Past the far edge unless q < n, or q == n landing exactly on the edge
  assign miss_x = (qx_r > Cw'(cols)) || ((qx_r == Cw'(cols)) && (rx_r != '0));
  assign miss_y = (qy_r > Cw'(rows)) || ((qy_r == Cw'(rows)) && (ry_r != '0));
  assign bumped = (cnt_rdata == gcpb_pkg::COUNT_MAX) ? cnt_rdata : cnt_rdata + Nw'(1);

  assign clearing = (state_r == S_CLEAR);
  assign pop      = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;   item_nxt = item_r;    step_nxt = step_r;
    walk_nxt = walk_r;     rx_nxt = rx_r;        ry_nxt = ry_r;
    qx_nxt = qx_r;         qy_nxt = qy_r;        col_nxt = col_r;
    row_nxt = row_r;       miss_nxt = miss_r;    idx_nxt = idx_r;
    ncells_nxt = ncells_r; next_nxt = next_r;    total_nxt = total_r;
    pv_nxt = pv_r;         pidx_nxt = pidx_r;
    res_index_nxt = res_index_r; res_out_nxt = res_out_r;
    res_count_nxt = res_count_r; res_bid_nxt = res_bid_r;
    res_total_nxt = res_total_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_index_nxt = o_index_r; o_out_nxt = o_out_r; o_count_nxt = o_count_r;
    o_bid_nxt = o_bid_r;     o_total_nxt = o_total_r;
    cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0; cnt_raddr = '0;
    bid_we = 1'b0; bid_waddr = '0; bid_wdata = '0; bid_raddr = '0;

    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = walk_r[Aw-1:0];
        walk_nxt  = walk_r + Ww'(1);
        if (walk_r == gcpb_pkg::CellLimit - Ww'(1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          item_nxt      = q_item;
          res_index_nxt = '0;
          res_out_nxt   = 1'b0;
          res_count_nxt = '0;
          res_bid_nxt   = gcpb_pkg::NO_BLOCK;
          res_total_nxt = total_r;
          unique case (q_item.kind)
            gcpb_pkg::REQ_BIN: begin
              rx_nxt = '0; qx_nxt = q_item.off_x;
              ry_nxt = '0; qy_nxt = q_item.off_y;
              step_nxt  = '0;
              state_nxt = S_DIV;
            end
            gcpb_pkg::REQ_NUMBER: begin
              ncells_nxt = (area > (2*Dw)'(gcpb_pkg::MaxCells)) ?
                           Iw'(gcpb_pkg::MaxCells) : area[Iw-1:0];
              walk_nxt  = '0;
              pv_nxt    = 1'b0;
              next_nxt  = '0;
              state_nxt = S_NUM;
            end
            gcpb_pkg::REQ_READ: state_nxt = S_RRD;
            default:            state_nxt = S_OUT;
          endcase
        end
      end
      S_DIV: begin
        {rx_nxt, qx_nxt} = stx;
        {ry_nxt, qy_nxt} = sty;
        step_nxt = step_r + gcpb_pkg::StepW'(1);
        if (step_r == gcpb_pkg::StepW'(gcpb_pkg::DivSteps - 1)) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // Clamp a point on the far edge into the last column or row
        col_nxt   = (qx_r >= Cw'(cols)) ? Aw'(cols - Dw'(1)) : qx_r[Aw-1:0];
        row_nxt   = (qy_r >= Cw'(rows)) ? Aw'(rows - Dw'(1)) : qy_r[Aw-1:0];
        miss_nxt  = item_r.neg | miss_x | miss_y;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        idx_nxt   = Xw'(row_r) * Xw'(cols) + Xw'(col_r);
        state_nxt = S_BRD;
      end
      S_BRD: begin
        cnt_raddr = idx_r[Aw-1:0];
        if (miss_r || (idx_r[Xw-1:Aw] != '0)) begin
          res_out_nxt = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_BWR;
        end
      end
      S_BWR: begin
        cnt_we        = 1'b1;
        cnt_waddr     = idx_r[Aw-1:0];
        cnt_wdata     = bumped;
        res_index_nxt = idx_r[Aw-1:0];
        res_count_nxt = bumped;
        state_nxt     = S_OUT;
      end
      S_NUM: begin
        // Read one cell per cycle; assign each id in the cycle after its read
        cnt_raddr = walk_r[Aw-1:0];
        if (pv_r) begin
          bid_we    = 1'b1;
          bid_waddr = pidx_r;
          if ((Iw'(pidx_r) < ncells_r) && (cnt_rdata != '0)) begin
            bid_wdata = next_r;
            next_nxt  = next_r + Iw'(1);
          end else begin
            bid_wdata = gcpb_pkg::NO_BLOCK;
          end
        end
        pv_nxt   = !walk_r[Ww-1];
        pidx_nxt = walk_r[Aw-1:0];
        if (!walk_r[Ww-1]) walk_nxt = walk_r + Ww'(1);
        if (walk_r[Ww-1] && !pv_r) begin
          total_nxt     = next_r;
          res_total_nxt = next_r;
          state_nxt     = S_OUT;
        end
      end
      S_RRD: begin
        cnt_raddr = item_r.sel;
        bid_raddr = item_r.sel;
        state_nxt = S_RDONE;
      end
      S_RDONE: begin
        res_index_nxt = item_r.sel;
        res_count_nxt = cnt_rdata;
        res_bid_nxt   = bid_rdata;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_index_nxt   = res_index_r;
          o_out_nxt     = res_out_r;
          o_count_nxt   = res_count_r;
          o_bid_nxt     = res_bid_r;
          o_total_nxt   = res_total_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;   step_r <= step_nxt;
    rx_r <= rx_nxt;       ry_r <= ry_nxt;
    qx_r <= qx_nxt;       qy_r <= qy_nxt;
    col_r <= col_nxt;     row_r <= row_nxt;
    miss_r <= miss_nxt;   idx_r <= idx_nxt;
    ncells_r <= ncells_nxt; next_r <= next_nxt; pidx_r <= pidx_nxt;
    res_index_r <= res_index_nxt; res_out_r <= res_out_nxt;
    res_count_r <= res_count_nxt; res_bid_r <= res_bid_nxt;
    res_total_r <= res_total_nxt;
    o_index_r <= o_index_nxt; o_out_r <= o_out_nxt; o_count_r <= o_count_nxt;
    o_bid_r <= o_bid_nxt;     o_total_r <= o_total_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      walk_r      <= '0;
      pv_r        <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      pv_r        <= pv_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_index   = o_index_r;
  assign out_outside      = o_out_r;
  assign out_cell_count   = o_count_r;
  assign out_block_id     = o_bid_r;
  assign out_total_blocks = o_total_r;

endmodule

>>> hdl/grid_cell_point_binning_top.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  req_type, point_x, point_y, cell_select
// out      output     out_valid/out_stall cell_index, outside, cell_count,
//                                         block_id, total_blocks
// cfg      input      cfg_we             cfg_index, cfg_wdata (write only)
//
// A bin request runs through the 32-step serial divider that finds column and
// row side by side. Numbering walks all 4096 cells through the count memory's
// read port. After reset a clearing pass zeroes the count memory, and in_stall
// stays high meanwhile. A two-beat queue takes requests while the back end
// works, and one output register holds a result while out_stall is high.
module grid_cell_point_binning_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic signed [gcpb_pkg::CoordW-1:0] in_point_x,
  input  logic signed [gcpb_pkg::CoordW-1:0] in_point_y,
  input  logic [gcpb_pkg::CellAw-1:0]       in_cell_select,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gcpb_pkg::CellAw-1:0]       out_cell_index,
  output logic                              out_outside,
  output logic [gcpb_pkg::CountW-1:0]       out_cell_count,
  output logic signed [gcpb_pkg::IdW-1:0]   out_block_id,
  output logic [gcpb_pkg::IdW-1:0]          out_total_blocks,
  input  logic                              cfg_we,
  input  logic [gcpb_pkg::CfgAw-1:0]        cfg_index,
  input  logic [gcpb_pkg::CoordW-1:0]       cfg_wdata
);

  gcpb_pkg::cfg_t  cfg_r, cfg_nxt;
  gcpb_pkg::item_t q_item;
  logic            q_valid, pop, clearing;

  // Register file: indexes beyond the list drop the beat
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        gcpb_pkg::CFG_ORIGIN_X:  cfg_nxt.origin_x  = cfg_wdata;
        gcpb_pkg::CFG_TOP_Y:     cfg_nxt.top_y     = cfg_wdata;
        gcpb_pkg::CFG_CELL_SIZE: cfg_nxt.cell_size = cfg_wdata[gcpb_pkg::SizeW-1:0];
        gcpb_pkg::CFG_GRID_COLS: cfg_nxt.grid_cols = cfg_wdata[gcpb_pkg::DimW-1:0];
        gcpb_pkg::CFG_GRID_ROWS: cfg_nxt.grid_rows = cfg_wdata[gcpb_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x  <= '0;
      cfg_r.top_y     <= '0;
      cfg_r.cell_size <= gcpb_pkg::SizeW'(1);
      cfg_r.grid_cols <= gcpb_pkg::DimW'(1);
      cfg_r.grid_rows <= gcpb_pkg::DimW'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: take the beat, compute edge offsets, queue it
  gcpb_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .hold(clearing),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_cell_select(in_cell_select),
    .pop(pop), .q_valid(q_valid), .q_item(q_item)
  );

  // Back: divide, update counts, number cells, serve reads, drive the result register
  gcpb_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_item(q_item), .pop(pop), .clearing(clearing),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cell_index(out_cell_index), .out_outside(out_outside),
    .out_cell_count(out_cell_count), .out_block_id(out_block_id),
    .out_total_blocks(out_total_blocks)
  );

endmodule

>>> hdl/gcpb_checker.sv
module gcpb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [gcpb_pkg::CellAw-1:0]       out_cell_index,
  input logic                              out_outside,
  input logic [gcpb_pkg::CountW-1:0]       out_cell_count,
  input logic signed [gcpb_pkg::IdW-1:0]   out_block_id,
  input logic [gcpb_pkg::IdW-1:0]          out_total_blocks
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_count)
      && $stable(out_cell_index))
    else $error("result changed under stall");

  // Leaving reset starts the clearing pass, so input is held off
  a_clear_stall: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> in_stall)
    else $error("input open during clearing pass");

  // A point off the grid is never counted
  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outside |-> out_cell_count == '0 && out_cell_index == '0
      && out_block_id == -1)
    else $error("outside result carries data");

  // A real block id is below the total of the numbering that gave it
  a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_id != -1 |->
      !out_block_id[gcpb_pkg::IdW-1] && (out_block_id < out_total_blocks))
    else $error("block id beyond total");

endmodule

bind grid_cell_point_binning_top gcpb_checker u_gcpb_checker (.*);
